FILE: hw/rtl/ptrs_pkg.sv
package ptrs_pkg;

    // Request codes carried on s_tuser
    typedef enum logic [2:0] {
        REQ_ADD  = 3'd0,
        REQ_DEL  = 3'd1,
        REQ_TICK = 3'd2,
        REQ_NEXT = 3'd3,
        REQ_DONE = 3'd4
    } req_t;

    // Status codes carried on m_tuser
    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_FULL        = 3'd1,
        ST_NOT_FOUND   = 3'd2,
        ST_NONE_READY  = 3'd3,
        ST_BUSY        = 3'd4,
        ST_NOT_RUNNING = 3'd5
    } status_t;

    // Slot phase
    typedef enum logic [1:0] {
        PH_READY   = 2'd0,
        PH_RUNNING = 2'd1,
        PH_BLOCKED = 2'd2
    } phase_t;

    localparam int IdW     = 8;
    localparam int PeriodW = 16;
    localparam int SlotOutW = 3;

    // One slot table word as stored in RAM
    typedef struct packed {
        logic [PeriodW-1:0] delay;
        logic [PeriodW-1:0] period;
        logic [IdW-1:0]     id;
    } slot_word_t;

endpackage

FILE: hw/rtl/ptrs_ram.sv
module ptrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/periodic_task_release_scheduler.sv
// Channel  | Ports                     | tuser          | tdata (lowest bit up)
// ---------+---------------------------+----------------+------------------------------------
// request  | s_tvalid s_tready s_tdata | [2:0] req_type | [7:0] task_id, [23:8] period_ticks
// result   | m_tvalid m_tready m_tdata | [2:0] status   | [2:0] slot_index, [10:3] dispatched_id
//
// Walk: add, delete, tick and next walk the slot table one slot per cycle through a
// single RAM read port and one evaluate stage; done reads only the running slot, and
// next while running, done while idle and unused codes are answered without a read.
// Reset: synchronous, active low; valid, phase, written marks and control clear at once.
// Stalls: s_tready is high only while idle; a finished result waits for a free output
// register, and the next item may be accepted while that register is still held.
module periodic_task_release_scheduler #(
    parameter int SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // [7:0] task_id, [23:8] period_ticks
    input  logic [2:0]  s_tuser,  // [2:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // [2:0] slot_index, [10:3] dispatched_id, [15:11] zero
    output logic [2:0]  m_tuser   // [2:0] status
);

    import ptrs_pkg::*;

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int WW = $bits(slot_word_t);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    req_t               req_reg, req_next;
    logic [IdW-1:0]     id_reg, id_next;
    logic [PeriodW-1:0] period_reg, period_next;
    logic [IW-1:0]      iss_addr_reg, iss_addr_next;
    logic [CW-1:0]      iss_left_reg, iss_left_next;
    logic               eval_vld_reg, eval_vld_next;
    logic [IW-1:0]      eval_idx_reg, eval_idx_next;
    logic               valid_reg [SLOTS];
    logic               valid_next [SLOTS];
    phase_t             phase_reg [SLOTS];
    phase_t             phase_next [SLOTS];
    logic               wmark_reg [SLOTS];
    logic               wmark_next [SLOTS];
    logic               running_reg, running_next;
    logic [IW-1:0]      run_slot_reg, run_slot_next;
    logic [IW-1:0]      scan_ptr_reg, scan_ptr_next;
    status_t            res_status_reg, res_status_next;
    logic [SlotOutW-1:0] res_slot_reg, res_slot_next;
    logic [IdW-1:0]     res_id_reg, res_id_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [15:0]        m_tdata_reg, m_tdata_next;
    logic [2:0]         m_tuser_reg, m_tuser_next;

    logic               ram_wr_en;
    logic [IW-1:0]      ram_wr_addr;
    slot_word_t         ram_wr_data;
    logic               ram_rd_en;
    logic [WW-1:0]      ram_rd_data;
    slot_word_t         rd_word;
    logic [IW+SlotOutW-1:0] eval_idx_ext;
    req_t               in_req;

    ptrs_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (iss_addr_reg),
        .rd_data (ram_rd_data)
    );

    // Unwritten slots read as their reset value of zero
    assign rd_word      = wmark_reg[eval_idx_reg] ? slot_word_t'(ram_rd_data) : '0;
    assign eval_idx_ext = {{SlotOutW{1'b0}}, eval_idx_reg};
    assign in_req       = req_t'(s_tuser);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        id_next         = id_reg;
        period_next     = period_reg;
        iss_addr_next   = iss_addr_reg;
        iss_left_next   = iss_left_reg;
        eval_vld_next   = 1'b0;
        eval_idx_next   = eval_idx_reg;
        valid_next      = valid_reg;
        phase_next      = phase_reg;
        wmark_next      = wmark_reg;
        running_next    = running_reg;
        run_slot_next   = run_slot_reg;
        scan_ptr_next   = scan_ptr_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_id_next     = res_id_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = eval_idx_reg;
        ram_wr_data     = rd_word;
        ram_rd_en       = 1'b0;

        // Drop the output item once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next        = in_req;
                    id_next         = s_tdata[7:0];
                    period_next     = s_tdata[23:8];
                    res_status_next = ST_OK;
                    res_slot_next   = '0;
                    res_id_next     = '0;
                    state_next      = S_SCAN;
                    iss_addr_next   = '0;
                    iss_left_next   = CW'(SLOTS);
                    // Answer early where no slot walk is needed
                    case (in_req)
                        REQ_NEXT: begin
                            iss_addr_next = scan_ptr_reg;
                            if (running_reg) begin
                                res_status_next = ST_BUSY;
                                state_next      = S_OUT;
                            end
                        end
                        REQ_DONE: begin
                            iss_addr_next = run_slot_reg;
                            iss_left_next = CW'(1);
                            if (!running_reg) begin
                                res_status_next = ST_NOT_RUNNING;
                                state_next      = S_OUT;
                            end
                        end
                        REQ_ADD, REQ_DEL, REQ_TICK: begin
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                // Issue the read of the next slot
                if (iss_left_reg != '0) begin
                    ram_rd_en     = 1'b1;
                    eval_vld_next = 1'b1;
                    eval_idx_next = iss_addr_reg;
                    iss_left_next = iss_left_reg - CW'(1);
                    iss_addr_next = (iss_addr_reg == IW'(SLOTS - 1)) ? '0
                                                                    : iss_addr_reg + IW'(1);
                end

                // Evaluate the slot read in the previous cycle
                if (eval_vld_reg) begin
                    unique case (req_reg)
                        REQ_ADD: begin
                            if (!valid_reg[eval_idx_reg]) begin
                                ram_wr_en                = 1'b1;
                                ram_wr_data.id           = id_reg;
                                ram_wr_data.period       = period_reg;
                                ram_wr_data.delay        = period_reg;
                                valid_next[eval_idx_reg] = 1'b1;
                                wmark_next[eval_idx_reg] = 1'b1;
                                phase_next[eval_idx_reg] = PH_BLOCKED;
                                res_slot_next            = eval_idx_ext[SlotOutW-1:0];
                                state_next               = S_OUT;
                            end
                        end
                        REQ_DEL: begin
                            if (rd_word.id == id_reg) begin
                                valid_next[eval_idx_reg] = 1'b0;
                                res_slot_next            = eval_idx_ext[SlotOutW-1:0];
                                state_next               = S_OUT;
                            end
                        end
                        REQ_TICK: begin
                            if (phase_reg[eval_idx_reg] == PH_BLOCKED) begin
                                if (rd_word.delay != '0) begin
                                    ram_wr_en         = 1'b1;
                                    ram_wr_data.delay = rd_word.delay - PeriodW'(1);
                                end else begin
                                    phase_next[eval_idx_reg] = PH_READY;
                                end
                            end
                        end
                        REQ_NEXT: begin
                            if (valid_reg[eval_idx_reg] &&
                                phase_reg[eval_idx_reg] == PH_READY) begin
                                phase_next[eval_idx_reg] = PH_RUNNING;
                                running_next             = 1'b1;
                                run_slot_next            = eval_idx_reg;
                                scan_ptr_next = (eval_idx_reg == IW'(SLOTS - 1)) ? '0
                                                : eval_idx_reg + IW'(1);
                                res_slot_next            = eval_idx_ext[SlotOutW-1:0];
                                res_id_next              = rd_word.id;
                                state_next               = S_OUT;
                            end
                        end
                        REQ_DONE: begin
                            ram_wr_en                = 1'b1;
                            ram_wr_data.delay        = rd_word.period;
                            phase_next[eval_idx_reg] = PH_BLOCKED;
                            running_next             = 1'b0;
                            res_slot_next            = eval_idx_ext[SlotOutW-1:0];
                            state_next               = S_OUT;
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase

                    // Walk ended without a hit
                    if (iss_left_reg == '0 && state_next == S_SCAN) begin
                        state_next = S_OUT;
                        case (req_reg)
                            REQ_ADD:  res_status_next = ST_FULL;
                            REQ_DEL:  res_status_next = ST_NOT_FOUND;
                            REQ_NEXT: res_status_next = ST_NONE_READY;
                            default:  res_status_next = ST_OK;
                        endcase
                    end
                end
            end

            S_OUT: begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = res_status_reg;
                    m_tdata_next  = {5'b0, res_id_reg, res_slot_reg};
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            eval_vld_reg <= 1'b0;
            running_reg  <= 1'b0;
            run_slot_reg <= '0;
            scan_ptr_reg <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++) begin
                valid_reg[i] <= 1'b0;
                phase_reg[i] <= PH_READY;
                wmark_reg[i] <= 1'b0;
            end
        end else begin
            state_reg    <= state_next;
            eval_vld_reg <= eval_vld_next;
            running_reg  <= running_next;
            run_slot_reg <= run_slot_next;
            scan_ptr_reg <= scan_ptr_next;
            m_tvalid_reg <= m_tvalid_next;
            valid_reg    <= valid_next;
            phase_reg    <= phase_next;
            wmark_reg    <= wmark_next;
        end
        req_reg        <= req_next;
        id_reg         <= id_next;
        period_reg     <= period_next;
        iss_addr_reg   <= iss_addr_next;
        iss_left_reg   <= iss_left_next;
        eval_idx_reg   <= eval_idx_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_id_reg     <= res_id_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

endmodule

FILE: verif/periodic_task_release_scheduler_tb.sv
module periodic_task_release_scheduler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ptrs_pkg::*;

    localparam int SLOT_COUNT = 8;
    // Cycles the block may still need after its last result (scan plus output load)
    localparam int SETTLE_CYCLES = 2 * SLOT_COUNT + 8;
    // Request codes that the block answers without touching its table
    localparam logic [2:0] REQ_RSVD_LO = 3'd5;
    localparam logic [2:0] REQ_RSVD_HI = 3'd7;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct {
        status_t    status;
        logic [2:0] slot;
        logic [7:0] disp_id;
    } sched_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // [7:0] task_id, [23:8] period_ticks
    logic [2:0]  s_tuser = '0;   // [2:0] req_type
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;        // [2:0] slot_index, [10:3] dispatched_id, [15:11] zero
    logic [2:0]  m_tuser;        // [2:0] status

    // Predicted scheduler state
    logic [7:0]  tbl_id     [SLOT_COUNT];
    logic        tbl_valid  [SLOT_COUNT];
    logic [15:0] tbl_period [SLOT_COUNT];
    logic [15:0] tbl_delay  [SLOT_COUNT];
    phase_t      tbl_phase  [SLOT_COUNT];
    logic        run_active;
    int          run_slot;
    int          scan_ptr;

    sched_result_t due_results[$];
    int  mismatch_count = 0;
    bit  src_calm = 1'b0;
    bit  snk_calm = 1'b0;

    periodic_task_release_scheduler #(
        .SLOTS(SLOT_COUNT)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Apply one request to the predicted table and return its answer
    function automatic sched_result_t schedule_step(logic [2:0] req, logic [7:0] id,
                                                    logic [15:0] per);
        sched_result_t r;
        bit hit;
        int s;
        r.status = ST_OK;
        r.slot = '0;
        r.disp_id = '0;
        hit = 1'b0;
        case (req)
            REQ_ADD: begin
                r.status = ST_FULL;
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    if (!hit && !tbl_valid[k]) begin
                        hit = 1'b1;
                        tbl_id[k] = id;
                        tbl_valid[k] = 1'b1;
                        tbl_period[k] = per;
                        tbl_delay[k] = per;
                        tbl_phase[k] = PH_BLOCKED;
                        r.status = ST_OK;
                        r.slot = k[2:0];
                    end
                end
            end
            REQ_DEL: begin
                r.status = ST_NOT_FOUND;
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    if (!hit && tbl_id[k] == id) begin
                        hit = 1'b1;
                        tbl_valid[k] = 1'b0;
                        r.status = ST_OK;
                        r.slot = k[2:0];
                    end
                end
            end
            REQ_TICK: begin
                // Blocked slots count down even when invalid
                for (int k = 0; k < SLOT_COUNT; k++) begin
                    if (tbl_phase[k] == PH_BLOCKED) begin
                        if (tbl_delay[k] != 16'd0) tbl_delay[k] = tbl_delay[k] - 16'd1;
                        else tbl_phase[k] = PH_READY;
                    end
                end
            end
            REQ_NEXT: begin
                if (run_active) begin
                    r.status = ST_BUSY;
                end else begin
                    r.status = ST_NONE_READY;
                    for (int k = 0; k < SLOT_COUNT; k++) begin
                        s = (scan_ptr + k) % SLOT_COUNT;
                        if (!hit && tbl_valid[s] && tbl_phase[s] == PH_READY) begin
                            hit = 1'b1;
                            tbl_phase[s] = PH_RUNNING;
                            run_active = 1'b1;
                            run_slot = s;
                            scan_ptr = (s + 1) % SLOT_COUNT;
                            r.status = ST_OK;
                            r.slot = s[2:0];
                            r.disp_id = tbl_id[s];
                        end
                    end
                end
            end
            REQ_DONE: begin
                if (!run_active) begin
                    r.status = ST_NOT_RUNNING;
                end else begin
                    // Reload and block even if the slot was deleted meanwhile
                    tbl_delay[run_slot] = tbl_period[run_slot];
                    tbl_phase[run_slot] = PH_BLOCKED;
                    run_active = 1'b0;
                    r.slot = run_slot[2:0];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic int draw_gap(bit calm);
        return calm ? 0 : $urandom_range(0, 11);
    endfunction

    // Send one item; valid stays high when the next item follows without a gap
    task automatic issue_request(input logic [2:0] req, input logic [7:0] id,
                                 input logic [15:0] per);
        int gap;
        gap = draw_gap(src_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {per, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        due_results.push_back(schedule_step(req, id, per));
    endtask

    // Hold off the sender until every expected item has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int exp_v, input int got_v);
        if (exp_v != got_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
            mismatch_count++;
        end
    endtask

    // Result side: random stall before each item, then compare with the oldest prediction
    initial begin
        int stall;
        sched_result_t exp_r;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_gap(snk_calm);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d tdata %h",
                         $time, m_tuser, m_tdata);
                mismatch_count++;
            end else begin
                exp_r = due_results.pop_front();
                check_field("status", int'(exp_r.status), int'(m_tuser));
                check_field("slot_index", int'(exp_r.slot), int'(m_tdata[2:0]));
                check_field("dispatched_id", int'(exp_r.disp_id), int'(m_tdata[10:3]));
                check_field("tdata padding", 0, int'(m_tdata[15:11]));
            end
        end
    end

    // Empty table: none-ready, not-running and not-found answers, delete of a never-written zero id, unused codes
    task automatic test_idle_table();
        issue_request(REQ_NEXT, 8'h00, 16'h0000);
        issue_request(REQ_DONE, 8'h00, 16'h0000);
        issue_request(REQ_DEL, 8'h00, 16'h0000);
        issue_request(REQ_DEL, 8'h5A, 16'hFFFF);
        for (logic [3:0] c = 4'(REQ_RSVD_LO); c <= 4'(REQ_RSVD_HI); c++)
            issue_request(c[2:0], 8'($urandom), 16'($urandom));
        issue_request(REQ_TICK, 8'hFF, 16'hFFFF);
    endtask

    // Fill every slot with extreme ids and periods, then overflow
    task automatic test_fill_table();
        issue_request(REQ_ADD, 8'hFF, 16'h0000);
        issue_request(REQ_ADD, 8'h00, 16'hFFFF);
        issue_request(REQ_ADD, 8'h55, 16'h0001);
        issue_request(REQ_ADD, 8'hAA, 16'h0002);
        issue_request(REQ_ADD, 8'h01, 16'h0000);
        issue_request(REQ_ADD, 8'h80, 16'h8000);
        issue_request(REQ_ADD, 8'h7F, 16'h7FFF);
        issue_request(REQ_ADD, 8'h02, 16'h5555);
        issue_request(REQ_ADD, 8'h33, 16'h0003);
    endtask

    // Release, dispatch, busy, delete while running, done, rotate
    task automatic test_dispatch_cycle();
        issue_request(REQ_TICK, 8'h00, 16'h0000);
        issue_request(REQ_NEXT, 8'h00, 16'h0000);
        issue_request(REQ_NEXT, 8'h00, 16'h0000);
        issue_request(REQ_DEL, 8'hFF, 16'h0000);
        issue_request(REQ_DONE, 8'h00, 16'h0000);
        issue_request(REQ_NEXT, 8'h00, 16'h0000);
        issue_request(REQ_DONE, 8'h00, 16'h0000);
        drain_results();
    endtask

    // Mostly well-formed traffic over a small id pool with short periods
    task automatic test_random_traffic();
        int counted;
        int w;
        logic [2:0] req;
        logic [7:0] id;
        logic [15:0] per;
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 100 == 0) begin
                src_calm = ($urandom_range(0, 3) == 0);
                snk_calm = ($urandom_range(0, 3) == 0);
            end
            w = $urandom_range(0, 99);
            if (w < 15) req = REQ_ADD;
            else if (w < 25) req = REQ_DEL;
            else if (w < 55) req = REQ_TICK;
            else if (w < 75) req = REQ_NEXT;
            else if (w < 95) req = REQ_DONE;
            else req = 3'($urandom_range(REQ_RSVD_LO, REQ_RSVD_HI));
            id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 11));
            if (req == REQ_DEL && $urandom_range(0, 1) == 1)
                id = tbl_id[$urandom_range(0, SLOT_COUNT - 1)];
            per = ($urandom_range(0, 49) == 0) ? 16'($urandom_range(0, 65535))
                                               : 16'($urandom_range(0, 4));
            issue_request(req, id, per);
            counted++;
        end
        src_calm = 1'b0;
        snk_calm = 1'b0;
    endtask

    initial begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
            tbl_id[k] = '0;
            tbl_valid[k] = 1'b0;
            tbl_period[k] = '0;
            tbl_delay[k] = '0;
            tbl_phase[k] = PH_READY;
        end
        run_active = 1'b0;
        run_slot = 0;
        scan_ptr = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_idle_table();
        test_fill_table();
        test_dispatch_cycle();
        test_random_traffic();
        drain_results();
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/ptrs_pkg.sv
hw/rtl/ptrs_ram.sv
hw/rtl/periodic_task_release_scheduler.sv
verif/periodic_task_release_scheduler_tb.sv
